@@ rtl/sha_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_pkg
// Shared types, constants and round functions of the SHA-256 stream hasher.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_PAD,
    ST_EMIT
  } state_e;

  typedef logic [31:0] word_t;

  typedef struct packed {
    logic start;
    logic init;
    logic fold;
  } core_ctl_t;

  localparam word_t H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PAD_BYTE = 8'h80;
  localparam logic [5:0] LAST_POS = 6'h3F;
  localparam logic [6:0] LEN_POS  = 7'd56;

  function automatic word_t ror(input word_t x, input int n);
    ror = (x >> n) | (x << (32 - n));
  endfunction

endpackage

@@ rtl/sha_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha_core
// One SHA-256 round per cycle over a 16-word rolling schedule.
// ----------------------------------------------------------------------------
module sha_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sha_pkg::core_ctl_t  ctl_i,
  input  logic [511:0]        block_i,
  output logic                busy_o,
  output sha_pkg::word_t      hash_o [8]
);

  sha_pkg::word_t h_q [8];
  sha_pkg::word_t v_q [8];
  sha_pkg::word_t w_q [16];
  logic [5:0]     rnd_q;
  logic           busy_q;

  sha_pkg::word_t w_cur, w2, w15, s0, s1, t1, t2;

  always_comb begin
    w2  = w_q[14];
    w15 = w_q[1];
    s1  = sha_pkg::ror(w2, 17) ^ sha_pkg::ror(w2, 19) ^ (w2 >> 10);
    s0  = sha_pkg::ror(w15, 7) ^ sha_pkg::ror(w15, 18) ^ (w15 >> 3);
    w_cur = (rnd_q < 6'd16) ? w_q[0] : (s1 + w_q[9] + s0 + w_q[0]);
    t1 = v_q[7] + (sha_pkg::ror(v_q[4], 6) ^ sha_pkg::ror(v_q[4], 11) ^
         sha_pkg::ror(v_q[4], 25)) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6])) +
         sha_pkg::ROUND_K[rnd_q] + w_cur;
    t2 = (sha_pkg::ror(v_q[0], 2) ^ sha_pkg::ror(v_q[0], 13) ^
         sha_pkg::ror(v_q[0], 22)) +
         ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  // window: w_q[0] is word r, rolled left each round
  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      for (int j = 0; j < 16; j++) begin
        w_q[j] <= block_i[511 - 32*j -: 32];
      end
      for (int j = 0; j < 8; j++) begin
        v_q[j] <= h_q[j];
      end
    end else if (busy_q) begin
      for (int j = 0; j < 15; j++) begin
        w_q[j] <= w_q[j+1];
      end
      w_q[15] <= w_cur;
      v_q[7] <= v_q[6];
      v_q[6] <= v_q[5];
      v_q[5] <= v_q[4];
      v_q[4] <= v_q[3] + t1;
      v_q[3] <= v_q[2];
      v_q[2] <= v_q[1];
      v_q[1] <= v_q[0];
      v_q[0] <= t1 + t2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      rnd_q  <= '0;
      h_q    <= sha_pkg::H_INIT;
    end else begin
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        rnd_q  <= '0;
      end else if (busy_q) begin
        rnd_q <= rnd_q + 6'd1;
        if (rnd_q == 6'd63) begin
          busy_q <= 1'b0;
        end
      end
      if (ctl_i.init) begin
        h_q <= sha_pkg::H_INIT;
      end else if (ctl_i.fold) begin
        for (int j = 0; j < 8; j++) begin
          h_q[j] <= h_q[j] + v_q[j];
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign hash_o = h_q;

endmodule

@@ rtl/sha256_stream_hasher.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_stream_hasher
// SHA-256 of a byte stream; emits eight digest words per message.
// ----------------------------------------------------------------------------
// Byte items are taken one per cycle, except the 64th of a block,
// which starts a compression: the load state, the round state, in which
// the sequencer waits until it sees the round loop finish, and the fold
// state, all with s_axis_tready low. An end-of-message item adds one or two
// padded compressions, each a pad state before those same states, then
// eight output items, one per cycle while m_axis_tready is high. The round
// loop of sha_core computes every compression.
module sha256_stream_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // data_byte
  input  logic [1:0]  s_axis_tuser,   // end_of_message, has_byte
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // digest_word
  output logic [2:0]  m_axis_tuser,   // word_index
  output logic        m_axis_tlast    // last_word
);

  sha_pkg::state_e state_q, state_d;
  logic [511:0] blk_q, blk_d;
  logic [63:0]  bits_q, bits_d;
  logic         eom_q, eom_d;
  logic         lenblk_q, lenblk_d;
  logic         padded_q, padded_d;
  logic [2:0]   idx_q, idx_d;
  logic         busy;
  sha_pkg::word_t   hash [8];
  sha_pkg::core_ctl_t ctl;

  logic [5:0] pos;
  logic       acc;
  logic       wr_en;
  logic [7:0] wr_data;
  logic       pad_fill;
  logic       pad_final;

  assign pos = bits_q[8:3];
  assign acc = s_axis_tvalid && s_axis_tready;

  sha_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (ctl),
    .block_i(blk_q),
    .busy_o (busy),
    .hash_o (hash)
  );

  always_comb begin
    state_d  = state_q;
    bits_d   = bits_q;
    eom_d    = eom_q;
    lenblk_d = lenblk_q;
    padded_d = padded_q;
    idx_d    = idx_q;
    ctl      = '0;
    wr_en    = 1'b0;
    wr_data  = s_axis_tdata;
    s_axis_tready = 1'b0;
    unique case (state_q)
      sha_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (acc) begin
          eom_d    = s_axis_tuser[1];
          lenblk_d = 1'b0;
          padded_d = 1'b0;
          if (s_axis_tuser[0]) begin
            wr_en  = 1'b1;
            bits_d = bits_q + 64'd8;
            if (pos == sha_pkg::LAST_POS) begin
              state_d = sha_pkg::ST_LOAD;
            end else if (s_axis_tuser[1]) begin
              state_d = sha_pkg::ST_PAD;
            end
          end else if (s_axis_tuser[1]) begin
            state_d = sha_pkg::ST_PAD;
          end
        end
      end
      sha_pkg::ST_LOAD: begin
        ctl.start = 1'b1;
        state_d   = sha_pkg::ST_ROUND;
      end
      sha_pkg::ST_ROUND: begin
        if (!busy) begin
          state_d = sha_pkg::ST_FOLD;
        end
      end
      sha_pkg::ST_FOLD: begin
        ctl.fold = 1'b1;
        if (!eom_q) begin
          state_d = sha_pkg::ST_IDLE;
        end else if (lenblk_q) begin
          idx_d   = '0;
          state_d = sha_pkg::ST_EMIT;
        end else begin
          state_d = sha_pkg::ST_PAD;
        end
      end
      sha_pkg::ST_PAD: begin
        // pad bytes are laid in by the buffer write below
        state_d  = sha_pkg::ST_LOAD;
        padded_d = 1'b1;
        if (pad_final) begin
          lenblk_d = 1'b1;
        end
      end
      sha_pkg::ST_EMIT: begin
        if (m_axis_tready) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'd7) begin
            ctl.init = 1'b1;
            bits_d   = '0;
            state_d  = sha_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = sha_pkg::ST_IDLE;
    endcase
  end

  // buffer: byte writes, and the padding fill before a padded compression
  assign pad_fill  = (state_q == sha_pkg::ST_PAD);
  assign pad_final = ({1'b0, pos} + 7'd1 <= sha_pkg::LEN_POS) || padded_q;

  always_comb begin
    blk_d = blk_q;
    if (wr_en) begin
      blk_d[8*(63 - int'(pos)) +: 8] = wr_data;
    end else if (pad_fill) begin
      for (int j = 0; j < 64; j++) begin
        if (pad_final && j >= 56) begin
          blk_d[8*(63-j) +: 8] = bits_q[8*(63-j) +: 8];
        end else if (padded_q) begin
          blk_d[8*(63-j) +: 8] = 8'h00;
        end else if (j == int'(pos)) begin
          blk_d[8*(63-j) +: 8] = sha_pkg::PAD_BYTE;
        end else if (j > int'(pos)) begin
          blk_d[8*(63-j) +: 8] = 8'h00;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= sha_pkg::ST_IDLE;
      bits_q   <= '0;
      eom_q    <= 1'b0;
      lenblk_q <= 1'b0;
      padded_q <= 1'b0;
      idx_q    <= '0;
    end else begin
      state_q  <= state_d;
      bits_q   <= bits_d;
      eom_q    <= eom_d;
      lenblk_q <= lenblk_d;
      padded_q <= padded_d;
      idx_q    <= idx_d;
    end
  end

  assign m_axis_tvalid = (state_q == sha_pkg::ST_EMIT);
  assign m_axis_tdata  = hash[idx_q];
  assign m_axis_tuser  = idx_q;
  assign m_axis_tlast  = (idx_q == 3'd7);

`ifndef ASSERT_OFF
  a_no_in_when_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |-> !s_axis_tready) else $error("input ready during compression");
  a_emit_after_fold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q) == sha_pkg::ST_FOLD)
    else $error("digest shown without final fold");
  a_last_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> bits_q == 64'd0)
    else $error("bit count not cleared after digest");
`endif

endmodule

@@ tb/sv/sha256_digest_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both streams of the hasher, computes SHA-256 of each message from
// the accepted byte items and compares every emitted digest word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  input  logic [31:0] m_axis_tdata,
  input  logic [2:0]  m_axis_tuser,
  input  logic        m_axis_tlast,
  output int          fail_count_o,
  output int          pending_o,
  output int          digest_count_o
);

  typedef struct {
    sha_pkg::word_t word;
    logic [2:0]     index;
    logic           last;
  } digest_word_t;

  localparam sha_pkg::word_t IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };
  localparam sha_pkg::word_t KC [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  sha_pkg::word_t chain [8];
  logic [7:0]     blk [64];
  logic [63:0]    bit_len;
  digest_word_t   digest_q [$];
  int             fails;
  int             digests;

  assign fail_count_o   = fails;
  assign pending_o      = digest_q.size();
  assign digest_count_o = digests;

  function automatic sha_pkg::word_t rotr(sha_pkg::word_t x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    sha_pkg::word_t w [16];
    sha_pkg::word_t v [8];
    sha_pkg::word_t wr, t1, t2, w2, w15;
    for (int j = 0; j < 16; j++)
      w[j] = {blk[4*j], blk[4*j+1], blk[4*j+2], blk[4*j+3]};
    v = chain;
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        w2  = w[(r - 2) & 15];
        w15 = w[(r - 15) & 15];
        wr = (rotr(w2, 17) ^ rotr(w2, 19) ^ (w2 >> 10)) + w[(r - 7) & 15]
           + (rotr(w15, 7) ^ rotr(w15, 18) ^ (w15 >> 3)) + w[r & 15];
        w[r & 15] = wr;
      end
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KC[r] + wr;
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) chain[j] += v[j];
  endtask

  task automatic absorb_item(logic [7:0] b, logic has_b, logic eom);
    int pos;
    digest_word_t d;
    if (has_b) begin
      pos = int'(bit_len[8:3]);
      blk[pos] = b;
      bit_len += 64'd8;
      if (pos == 63) compress();
    end
    if (eom) begin
      pos = int'(bit_len[8:3]);
      blk[pos] = 8'h80;
      pos++;
      if (pos > 56) begin
        for (int j = pos; j < 64; j++) blk[j] = 8'h00;
        compress();
        for (int j = 0; j < 56; j++) blk[j] = 8'h00;
      end else begin
        for (int j = pos; j < 56; j++) blk[j] = 8'h00;
      end
      for (int j = 0; j < 8; j++) blk[63 - j] = bit_len[8*j +: 8];
      compress();
      for (int j = 0; j < 8; j++) begin
        d.word = chain[j]; d.index = j[2:0]; d.last = (j == 7);
        digest_q.push_back(d);
      end
      chain = IV;
      bit_len = '0;
    end
  endtask

  initial begin
    chain = IV; bit_len = '0; fails = 0; digests = 0;
    for (int j = 0; j < 64; j++) blk[j] = 8'h00;
  end

  always @(posedge clk_i) begin
    digest_word_t e;
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      absorb_item(s_axis_tdata, s_axis_tuser[0], s_axis_tuser[1]);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest item: expected none, actual %h idx %0d last %0b",
                 $time, m_axis_tdata, m_axis_tuser, m_axis_tlast);
        fails++;
      end else begin
        e = digest_q.pop_front();
        if (e.word !== m_axis_tdata || e.index !== m_axis_tuser || e.last !== m_axis_tlast) begin
          $display("%0t: digest mismatch: expected %h idx %0d last %0b, actual %h idx %0d last %0b",
                   $time, e.word, e.index, e.last, m_axis_tdata, m_axis_tuser, m_axis_tlast);
          fails++;
        end
        if (e.last) digests++;
      end
    end
  end
endmodule

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream stimulus for the SHA-256 hasher: directed edge messages, then
// random messages of varied lengths with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [31:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;
  int          fail_count, pending, digest_count;
  int          stall_cycles = 0;
  int          stall_cycles_wd = 0;
  bit          calm = 1'b0;
  bit          timed_out = 1'b0;
  int          items_sent = 0;

  localparam int WATCHDOG = 20000;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sha256_stream_hasher u_dut (.*);

  sha256_digest_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast,
    .fail_count_o(fail_count), .pending_o(pending), .digest_count_o(digest_count)
  );

  // receiver: bursts of stall, none near the end
  always @(posedge clk_i) begin
    int n;
    if (calm || stall_cycles == 0) begin
      m_axis_tready <= 1'b1;
      if (!calm && $urandom_range(0, 15) == 0) begin
        n = $urandom_range(1, 16);
        stall_cycles <= n;
      end
    end else begin
      m_axis_tready <= 1'b0;
      stall_cycles <= stall_cycles - 1;
    end
  end

  always @(posedge clk_i) begin
    int idle;
    idle = 0;
    if (s_axis_tvalid && s_axis_tready) idle = 0;
    else if (m_axis_tvalid && m_axis_tready) idle = 0;
    else idle = 1;
    if (rst_ni && idle) begin
      stall_cycles_wd++;
      if (stall_cycles_wd >= WATCHDOG) begin
        $display("TB_ERROR");
        $finish;
      end
    end else begin
      stall_cycles_wd = 0;
    end
  end

  task automatic send(logic [7:0] b, logic has_b, logic eom);
    int gap;
    if (!calm && $urandom_range(0, 11) == 0) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= {eom, has_b};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent++;
  endtask

  task automatic send_message(int len, bit end_with_byte, bit noise);
    int k;
    k = 0;
    while (k < len) begin
      if (noise && $urandom_range(0, 9) == 0) begin
        send(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end else begin
        if (end_with_byte && k == len - 1) send(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else send(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        k++;
      end
    end
    if (!(end_with_byte && len > 0)) send(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  initial begin
    int len, r;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // directed: empty, idle item, all-ones/zeros bytes, pad boundaries
    send(8'hff, 1'b0, 1'b1);
    send(8'h00, 1'b0, 1'b0);
    send(8'h00, 1'b1, 1'b0);
    send(8'hff, 1'b1, 1'b1);
    send(8'hff, 1'b1, 1'b0);
    send(8'h00, 1'b0, 1'b1);
    send(8'haa, 1'b0, 1'b0);
    send(8'h55, 1'b1, 1'b1);
    drain();
    send_message(55, 1'b1, 1'b0);
    send_message(56, 1'b0, 1'b0);
    send_message(64, 1'b1, 1'b0);
    drain();
    while (items_sent < 240) begin
      r = $urandom_range(0, 9);
      if (r < 7) len = $urandom_range(0, 20);
      else len = $urandom_range(40, 70);
      if (items_sent > 200) calm = 1'b1;
      send_message(len, 1'($urandom_range(0, 1)), $urandom_range(0, 3) == 0);
    end
    drain();
    repeat (200) @(posedge clk_i);
    $display("Hashed %0d messages (%0d items): empty, pad-boundary and multi-block.",
             digest_count, items_sent);
    if (fail_count == 0 && pending == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end
endmodule
